>>> rtl/gmts_pkg.sv
package gmts_pkg;

  // Field widths
  localparam int unsigned ProbW  = 16;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned InvW   = 16;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ScoreW = 32;

  // Q.16 log domain
  localparam int unsigned FracW  = 16;
  localparam int unsigned LgW    = 21;              // log2 of values below 2^32
  localparam int unsigned MagW   = LgW + InvW - 8;  // temperature-scaled magnitude

  localparam logic [LgW-1:0]    Lg16Q16      = 21'h10_0000;  // 16.0
  localparam logic [LgW-1:0]    Lg17Q16      = 21'h11_0000;  // 17.0
  localparam logic [InvW-1:0]   InvTempReset = 16'd256;      // 1.0 in Q8.8

  // Candidate handed from the scoring pipe to the selector
  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     nonzero;
    logic                     last;
  } gmts_cand_t;

  // log2(1 + idx/2^tab_bits) in Q0.16 by repeated squaring; elaboration only
  function automatic logic [FracW-1:0] log_rom_entry(input int unsigned idx,
                                                      input int unsigned tab_bits);
    logic [63:0]      y;
    logic [FracW-1:0] r;
    y = ((64'd1 << tab_bits) + 64'(idx)) << (30 - tab_bits);
    r = '0;
    for (int k = 0; k < FracW; k++) begin
      y = (y * y) >> 30;
      r = {r[FracW-2:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        y    = y >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/gmts_in_if.sv
interface gmts_in_if import gmts_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ProbW-1:0] probability;
  logic [CodeW-1:0] uniform_code;
  logic             last_element;

  modport source (output valid, probability, uniform_code, last_element, input ready);
  modport sink   (input valid, probability, uniform_code, last_element, output ready);
endinterface

>>> rtl/gmts_out_if.sv
interface gmts_out_if import gmts_pkg::*;;
  logic            valid;
  logic            ready;
  logic [PosW-1:0] chosen_index;
  logic            any_chosen;

  modport source (output valid, chosen_index, any_chosen, input ready);
  modport sink   (input valid, chosen_index, any_chosen, output ready);
endinterface

>>> rtl/gmts_cfg_if.sv
interface gmts_cfg_if import gmts_pkg::*;;
  logic            valid;
  logic            ready;
  logic [InvW-1:0] inverse_temperature;

  modport source (output valid, inverse_temperature, input ready);
  modport sink   (input valid, inverse_temperature, output ready);
endinterface

>>> rtl/gumbel_max_token_sampler.sv
// Gumbel-max token sampler. Each input transaction carries one element of a
// probability vector (unsigned Q0.16) with its own uniform random code; the
// element flagged last closes the vector and produces one output transaction
// holding the index of the winner and whether any element was nonzero. Each
// element is scored as log2(p) * inverse_temperature - log2(-log2(u)) in
// Q.16 fixed point using a mantissa log ROM; the first strictly greatest
// score wins, zero probabilities never win, and an all-zero vector returns
// index 0 with any_chosen low. Throughput is one element per clock while
// not stalled; the result passes through the input register, the two
// scoring registers (log lookups, then temperature multiply with the gumbel
// log) and the result register. Elements keep flowing while a result waits
// to be taken; only a second last element stalls until the first result
// leaves. inverse_temperature is unsigned Q8.8 (reset 1.0); the user must
// write it only while idle, and the block does not enforce this.
module gumbel_max_token_sampler import gmts_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS   = 65536,
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gmts_in_if.sink     in_i,
  gmts_out_if.source  out_o,
  gmts_cfg_if.sink    cfg_i
);

  logic [InvW-1:0] inv_temp_q;
  logic            cand_valid;
  logic            cand_ready;
  gmts_cand_t      cand;

  // Config register: always ready, one transaction per cycle
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_temp_q <= InvTempReset;
    end else if (cfg_i.valid) begin
      inv_temp_q <= cfg_i.inverse_temperature;
    end
  end

  // Scoring pipe
  gmts_score #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_score (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .probability_i  (in_i.probability),
    .uniform_code_i (in_i.uniform_code),
    .last_element_i (in_i.last_element),
    .inv_temp_i     (inv_temp_q),
    .cand_valid_o   (cand_valid),
    .cand_ready_i   (cand_ready),
    .cand_o         (cand)
  );

  // Running max and result register
  gmts_select #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cand_valid_i   (cand_valid),
    .cand_ready_o   (cand_ready),
    .cand_i         (cand),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .chosen_index_o (out_o.chosen_index),
    .any_chosen_o   (out_o.any_chosen)
  );

endmodule

>>> rtl/gmts_log2.sv
// log2 of a nonzero integer in Q.16: leading-one position plus mantissa ROM.
module gmts_log2 import gmts_pkg::*; #(
  parameter int unsigned IN_W     = 16,
  parameter int unsigned TAB_BITS = 8
) (
  input  logic [IN_W-1:0]                val_i,
  output logic [$clog2(IN_W)+FracW-1:0]  lg_o
);

  localparam int unsigned EW      = $clog2(IN_W);
  localparam int unsigned TabSize = 1 << TAB_BITS;
  localparam int unsigned ExtW    = IN_W + TAB_BITS;

  logic [FracW-1:0]    rom [TabSize];
  logic [EW-1:0]       lead;
  logic [EW-1:0]       shamt;
  logic [ExtW-1:0]     norm;
  logic [TAB_BITS-1:0] mant;

  for (genvar gi = 0; gi < TabSize; gi++) begin : g_rom
    localparam logic [FracW-1:0] Entry = log_rom_entry(gi, TAB_BITS);
    assign rom[gi] = Entry;
  end

  always_comb begin
    lead = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (val_i[k]) begin
        lead = EW'(k);
      end
    end
    shamt = EW'(IN_W - 1) - lead;
    // zero-fill below the LSB so short values still give a full mantissa
    norm  = {val_i, {TAB_BITS{1'b0}}} << shamt;
    mant  = norm[ExtW-2 -: TAB_BITS];
    lg_o  = {lead, rom[mant]};
  end

endmodule

>>> rtl/gmts_score.sv
// Three-stage scoring pipe: raw item, log lookups, temperature multiply + gumbel log.
module gmts_score import gmts_pkg::*; #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ProbW-1:0] probability_i,
  input  logic [CodeW-1:0] uniform_code_i,
  input  logic             last_element_i,
  input  logic [InvW-1:0]  inv_temp_i,
  output logic             cand_valid_o,
  input  logic             cand_ready_i,
  output gmts_cand_t       cand_o
);

  localparam int unsigned LgPW = $clog2(ProbW) + FracW;
  localparam int unsigned LgUW = $clog2(CodeW + 1) + FracW;
  localparam int unsigned LgWW = $clog2(LgW) + FracW;

  // stage A: raw item
  logic             a_valid_q, a_valid_d;
  logic [ProbW-1:0] a_prob_q;
  logic [CodeW-1:0] a_code_q;
  logic             a_last_q;
  // stage B: -log2 p and -log2 u
  logic             b_valid_q, b_valid_d;
  logic [LgW-1:0]   b_lpmag_q, b_lpmag_d;
  logic [LgW-1:0]   b_w_q, b_w_d;
  logic             b_nz_q, b_last_q;
  // stage C: scaled term magnitude and log2(-log2 u)
  logic             c_valid_q, c_valid_d;
  logic [MagW-1:0]  c_mag_q, c_mag_d;
  logic [LgWW-1:0]  c_lgw_q;
  logic             c_nz_q, c_last_q;

  logic ready_a, ready_b, ready_c;
  logic [LgPW-1:0]      lg_p;
  logic [LgUW-1:0]      lg_u;
  logic [LgWW-1:0]      lg_w;
  logic [LgW+InvW-1:0]  prod;

  assign ready_c    = !c_valid_q || cand_ready_i;
  assign ready_b    = !b_valid_q || ready_c;
  assign ready_a    = !a_valid_q || ready_b;
  assign in_ready_o = ready_a;

  assign a_valid_d = ready_a ? in_valid_i : a_valid_q;
  assign b_valid_d = ready_b ? a_valid_q  : b_valid_q;
  assign c_valid_d = ready_c ? b_valid_q  : c_valid_q;

  gmts_log2 #(.IN_W(ProbW), .TAB_BITS(LOG_TABLE_BITS)) u_lg_p (
    .val_i (a_prob_q),
    .lg_o  (lg_p)
  );

  gmts_log2 #(.IN_W(CodeW + 1), .TAB_BITS(LOG_TABLE_BITS)) u_lg_u (
    .val_i ({a_code_q, 1'b1}),
    .lg_o  (lg_u)
  );

  gmts_log2 #(.IN_W(LgW), .TAB_BITS(LOG_TABLE_BITS)) u_lg_w (
    .val_i (b_w_q),
    .lg_o  (lg_w)
  );

  always_comb begin
    b_lpmag_d = Lg16Q16 - LgW'(lg_p);
    b_w_d     = Lg17Q16 - LgW'(lg_u);   // never below 1
    prod      = b_lpmag_q * inv_temp_i;
    c_mag_d   = prod[LgW+InvW-1:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a) begin
      a_prob_q <= probability_i;
      a_code_q <= uniform_code_i;
      a_last_q <= last_element_i;
    end
    if (ready_b) begin
      b_lpmag_q <= b_lpmag_d;
      b_w_q     <= b_w_d;
      b_nz_q    <= (a_prob_q != '0);
      b_last_q  <= a_last_q;
    end
    if (ready_c) begin
      c_mag_q  <= c_mag_d;
      c_lgw_q  <= lg_w;
      c_nz_q   <= b_nz_q;
      c_last_q <= b_last_q;
    end
  end

  // score = -mag - (log2(w) - 16)
  always_comb begin
    cand_o.score   = signed'(ScoreW'(Lg16Q16) - ScoreW'(c_mag_q) - ScoreW'(c_lgw_q));
    cand_o.nonzero = c_nz_q;
    cand_o.last    = c_last_q;
  end

  assign cand_valid_o = c_valid_q;

endmodule

>>> rtl/gmts_select.sv
// Running argmax over one vector and the result register.
module gmts_select import gmts_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cand_valid_i,
  output logic            cand_ready_o,
  input  gmts_cand_t      cand_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PosW-1:0] chosen_index_o,
  output logic            any_chosen_o
);

  logic                     out_valid_q, out_valid_d;
  logic [PosW-1:0]          index_q;
  logic                     any_q;
  logic [PosW-1:0]          pos_q, pos_d;
  logic signed [ScoreW-1:0] best_q, best_d;
  logic [PosW-1:0]          best_pos_q, best_pos_d;
  logic                     found_q, found_d;
  logic                     take, emit;
  logic [PosW:0]            pos_inc;

  // a last element needs the result register free
  assign cand_ready_o = !cand_i.last || !out_valid_q || out_ready_i;
  assign take         = cand_valid_i && cand_ready_o;
  assign emit         = take && cand_i.last;

  always_comb begin
    best_d     = best_q;
    best_pos_d = best_pos_q;
    found_d    = found_q;
    if (cand_i.nonzero && (!found_q || cand_i.score > best_q)) begin
      best_d     = cand_i.score;
      best_pos_d = pos_q;
    end
    if (cand_i.nonzero) begin
      found_d = 1'b1;
    end
    pos_inc = {1'b0, pos_q} + (PosW+1)'(1);
    pos_d   = (pos_inc >= (PosW+1)'(MAX_ELEMENTS)) ? '0 : pos_inc[PosW-1:0];
    out_valid_d = (out_valid_q && !out_ready_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      best_q      <= {1'b1, {(ScoreW-1){1'b0}}};
      best_pos_q  <= '0;
      found_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        pos_q      <= '0;
        best_q     <= {1'b1, {(ScoreW-1){1'b0}}};
        best_pos_q <= '0;
        found_q    <= 1'b0;
      end else if (take) begin
        pos_q      <= pos_d;
        best_q     <= best_d;
        best_pos_q <= best_pos_d;
        found_q    <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      index_q <= found_d ? best_pos_d : '0;
      any_q   <= found_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = index_q;
  assign any_chosen_o   = any_q;

endmodule
